// File: design/fspm_pkg.sv
// shared types and codes of the frame slot pool manager
`default_nettype none
package fspm_pkg;

    localparam logic [2:0] FN_SETUP    = 3'd0;
    localparam logic [2:0] FN_RECLAIM  = 3'd1;
    localparam logic [2:0] FN_GET      = 3'd2;
    localparam logic [2:0] FN_COMPLETE = 3'd3;
    localparam logic [2:0] FN_RELEASE  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_BAD_STATE = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_NO_ROOM   = 3'd4;

    localparam logic [1:0] REG_BUFFER_BYTES = 2'd0;
    localparam logic [1:0] REG_FRAME_BYTES  = 2'd1;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] release_offset;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_offset;
        logic [6:0]  free_slots;
        logic [6:0]  held_slots;
    } rsp_t;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_PUSH,
        SH_POP
    } shift_op_t;

    typedef struct packed {
        shift_op_t op;
        logic      ld_en;
    } chain_ctl_t;

endpackage
`default_nettype wire

// File: design/fspm_cell.sv
// one storage cell of the slot chain
`default_nettype none
module fspm_cell (
    input  wire logic               clk,
    input  wire fspm_pkg::shift_op_t op,
    input  wire logic               ld_sel,
    input  wire logic [31:0]        left_val,
    input  wire logic [31:0]        right_val,
    input  wire logic [31:0]        ld_val,
    output logic [31:0]             val
);

    logic [31:0] val_reg;
    logic [31:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ld_sel)
        begin
            val_next = ld_val;
        end
        else
        begin
            case (op)
                fspm_pkg::SH_PUSH: val_next = left_val;
                fspm_pkg::SH_POP:  val_next = right_val;
                default:           val_next = val_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule
`default_nettype wire

// File: design/fspm_chain.sv
// row of cells forming a stack with rotate support, head at cell 0
`default_nettype none
module fspm_chain #(
    parameter int DEPTH = 64,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire fspm_pkg::chain_ctl_t ctl,
    input  wire logic [31:0]          push_data,
    input  wire logic [IW-1:0]        ld_idx,
    output logic [31:0]               head
);

    logic [31:0] vals [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [31:0] left_v;
            logic [31:0] right_v;
            logic        sel;
            if (i == 0)
            begin : g_first
                assign left_v = push_data;
            end
            else
            begin : g_mid
                assign left_v = vals[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign right_v = vals[i];
            end
            else
            begin : g_inner
                assign right_v = vals[i+1];
            end
            // rotating head lands at the tail slot
            assign sel = ctl.ld_en && (ld_idx == IW'(i));
            fspm_cell u_cell (
                .clk       (clk),
                .op        (ctl.op),
                .ld_sel    (sel),
                .left_val  (left_v),
                .right_val (right_v),
                .ld_val    (vals[0]),
                .val       (vals[i])
            );
        end
    endgenerate

    assign head = vals[0];

endmodule
`default_nettype wire

// File: design/frame_slot_pool_manager.sv
// top level: request sequencer over the free and held slot chains
// get, complete and bad requests answer from idle; setup fills the free chain from the buffer;
// reclaim drains the held chain; release makes two passes over the held chain
// throughput: one request at a time, the next accepted after the result is taken
// the chains shift one slot per cycle, which sets the walk lengths
// reset clears counts, active frame and control; slot cells are not cleared
`default_nettype none
module frame_slot_pool_manager #(
    parameter int MAX_SLOTS = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire fspm_pkg::req_t   in_req,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output fspm_pkg::rsp_t        out_rsp,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [31:0]      cfg_data
);

    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_RECL,
        S_SCAN1,
        S_SCAN2
    } state_t;

    state_t         state_reg, state_next;
    logic [31:0]    buf_reg, frm_reg;
    logic [CW-1:0]  fcnt_reg, fcnt_next, hcnt_reg, hcnt_next;
    logic [31:0]    act_off_reg, act_off_next;
    logic           act_val_reg, act_val_next;
    logic [31:0]    rel_reg, rel_next, off_reg, off_next;
    logic [32:0]    end_reg, end_next;
    logic [CW-1:0]  step_reg, step_next, match_reg, match_next, seen_reg, seen_next;
    logic           ov_reg, ov_next;
    fspm_pkg::rsp_t rsp_reg, rsp_next;

    fspm_pkg::chain_ctl_t free_ctl, held_ctl;
    logic [31:0]          free_din, held_din, free_head, held_head;
    logic                 accept, hit, fin;
    logic [2:0]           fin_status;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_rsp   = rsp_reg;
    assign cfg_ready = 1'b1;
    assign hit       = (held_head == rel_reg);

    always_comb
    begin
        state_next   = state_reg;
        fcnt_next    = fcnt_reg;
        hcnt_next    = hcnt_reg;
        act_off_next = act_off_reg;
        act_val_next = act_val_reg;
        rel_next     = rel_reg;
        off_next     = off_reg;
        end_next     = end_reg;
        step_next    = step_reg;
        match_next   = match_reg;
        seen_next    = seen_reg;
        ov_next      = ov_reg;
        rsp_next     = rsp_reg;
        free_ctl     = '{op: fspm_pkg::SH_HOLD, ld_en: 1'b0};
        held_ctl     = '{op: fspm_pkg::SH_HOLD, ld_en: 1'b0};
        free_din     = held_head;
        held_din     = act_off_reg;
        fin          = 1'b0;
        fin_status   = fspm_pkg::ST_OK;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.granted_offset = '0;
                    case (in_req.func)
                        fspm_pkg::FN_SETUP:
                        begin
                            fcnt_next    = '0;
                            hcnt_next    = '0;
                            act_val_next = 1'b0;
                            act_off_next = '0;
                            if (frm_reg == '0)
                            begin
                                ov_next         = 1'b1;
                                rsp_next.status = fspm_pkg::ST_INVALID;
                                rsp_next.free_slots = '0;
                                rsp_next.held_slots = '0;
                            end
                            else
                            begin
                                off_next   = '0;
                                end_next   = {1'b0, frm_reg};
                                state_next = S_SETUP;
                            end
                        end
                        fspm_pkg::FN_RECLAIM:
                        begin
                            if (act_val_reg)
                            begin
                                act_val_next = 1'b0;
                                if (fcnt_reg < MAXC)
                                begin
                                    free_ctl.op = fspm_pkg::SH_PUSH;
                                    free_din    = act_off_reg;
                                    fcnt_next   = fcnt_reg + 1'b1;
                                end
                            end
                            state_next = S_RECL;
                        end
                        fspm_pkg::FN_GET:
                        begin
                            ov_next = 1'b1;
                            rsp_next.free_slots = 7'(fcnt_reg);
                            rsp_next.held_slots = 7'(hcnt_reg);
                            if (act_val_reg)
                            begin
                                rsp_next.status = fspm_pkg::ST_BAD_STATE;
                            end
                            else if (fcnt_reg == '0)
                            begin
                                rsp_next.status = fspm_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                free_ctl.op  = fspm_pkg::SH_POP;
                                fcnt_next    = fcnt_reg - 1'b1;
                                act_off_next = free_head;
                                act_val_next = 1'b1;
                                rsp_next.status         = fspm_pkg::ST_OK;
                                rsp_next.granted_offset = free_head;
                                rsp_next.free_slots     = 7'(fcnt_reg - 1'b1);
                            end
                        end
                        fspm_pkg::FN_COMPLETE:
                        begin
                            ov_next = 1'b1;
                            rsp_next.free_slots = 7'(fcnt_reg);
                            rsp_next.held_slots = 7'(hcnt_reg);
                            if (!act_val_reg)
                            begin
                                rsp_next.status = fspm_pkg::ST_BAD_STATE;
                            end
                            else
                            begin
                                act_val_next    = 1'b0;
                                rsp_next.status = fspm_pkg::ST_OK;
                                if (hcnt_reg < MAXC)
                                begin
                                    held_ctl.op = fspm_pkg::SH_PUSH;
                                    hcnt_next   = hcnt_reg + 1'b1;
                                    rsp_next.held_slots = 7'(hcnt_reg + 1'b1);
                                end
                            end
                        end
                        fspm_pkg::FN_RELEASE:
                        begin
                            rel_next   = in_req.release_offset;
                            step_next  = hcnt_reg;
                            match_next = '0;
                            state_next = S_SCAN1;
                        end
                        default:
                        begin
                            ov_next = 1'b1;
                            rsp_next.status     = fspm_pkg::ST_INVALID;
                            rsp_next.free_slots = 7'(fcnt_reg);
                            rsp_next.held_slots = 7'(hcnt_reg);
                        end
                    endcase
                end
            end
            S_SETUP:
            begin
                if (end_reg <= {1'b0, buf_reg})
                begin
                    if (fcnt_reg == MAXC)
                    begin
                        fcnt_next  = '0;
                        fin        = 1'b1;
                        fin_status = fspm_pkg::ST_NO_ROOM;
                    end
                    else
                    begin
                        free_ctl.op = fspm_pkg::SH_PUSH;
                        free_din    = off_reg;
                        fcnt_next   = fcnt_reg + 1'b1;
                        off_next    = off_reg + frm_reg;
                        end_next    = end_reg + {1'b0, frm_reg};
                    end
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            S_RECL:
            begin
                if (hcnt_reg != '0)
                begin
                    held_ctl.op = fspm_pkg::SH_POP;
                    hcnt_next   = hcnt_reg - 1'b1;
                    if (fcnt_reg < MAXC)
                    begin
                        free_ctl.op = fspm_pkg::SH_PUSH;
                        fcnt_next   = fcnt_reg + 1'b1;
                    end
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            S_SCAN1:
            begin
                // first pass counts matches; newest sits at the head
                if (step_reg != '0)
                begin
                    held_ctl  = '{op: fspm_pkg::SH_POP, ld_en: 1'b1};
                    step_next = step_reg - 1'b1;
                    if (hit)
                    begin
                        match_next = match_reg + 1'b1;
                    end
                end
                else if (match_reg == '0)
                begin
                    fin        = 1'b1;
                    fin_status = fspm_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    step_next  = hcnt_reg;
                    seen_next  = '0;
                    state_next = S_SCAN2;
                end
            end
            S_SCAN2:
            begin
                // the last match seen is the earliest held entry
                if (step_reg != '0)
                begin
                    step_next = step_reg - 1'b1;
                    if (hit)
                    begin
                        seen_next = seen_reg + 1'b1;
                    end
                    if (hit && (CW'(seen_reg + 1'b1) == match_reg))
                    begin
                        held_ctl.op = fspm_pkg::SH_POP;
                        hcnt_next   = hcnt_reg - 1'b1;
                        if (fcnt_reg < MAXC)
                        begin
                            free_ctl.op = fspm_pkg::SH_PUSH;
                            fcnt_next   = fcnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        held_ctl = '{op: fspm_pkg::SH_POP, ld_en: 1'b1};
                    end
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next              = S_IDLE;
            ov_next                 = 1'b1;
            rsp_next.status         = fin_status;
            rsp_next.granted_offset = '0;
            rsp_next.free_slots     = (fin_status == fspm_pkg::ST_NO_ROOM) ? 7'd0 : 7'(fcnt_reg);
            rsp_next.held_slots     = 7'(hcnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            buf_reg     <= '0;
            frm_reg     <= '0;
            fcnt_reg    <= '0;
            hcnt_reg    <= '0;
            act_off_reg <= '0;
            act_val_reg <= 1'b0;
            step_reg    <= '0;
            match_reg   <= '0;
            seen_reg    <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fcnt_reg    <= fcnt_next;
            hcnt_reg    <= hcnt_next;
            act_off_reg <= act_off_next;
            act_val_reg <= act_val_next;
            step_reg    <= step_next;
            match_reg   <= match_next;
            seen_reg    <= seen_next;
            ov_reg      <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fspm_pkg::REG_BUFFER_BYTES: buf_reg <= cfg_data;
                    fspm_pkg::REG_FRAME_BYTES:  frm_reg <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rel_reg <= rel_next;
        off_reg <= off_next;
        end_reg <= end_next;
        rsp_reg <= rsp_next;
    end

    fspm_chain #(.DEPTH(MAX_SLOTS), .IW(IW)) u_free (
        .clk       (clk),
        .ctl       (free_ctl),
        .push_data (free_din),
        .ld_idx    ('0),
        .head      (free_head)
    );

    fspm_chain #(.DEPTH(MAX_SLOTS), .IW(IW)) u_held (
        .clk       (clk),
        .ctl       (held_ctl),
        .push_data (held_din),
        .ld_idx    (IW'(hcnt_reg - 1'b1)),
        .head      (held_head)
    );

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= MAXC) else $error("free count above capacity");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hcnt_reg <= MAXC) else $error("held count above capacity");

    a_busy_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !ov_reg) else $error("result pending while busy");

    a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
        ((CW+1)'(fcnt_reg) + (CW+1)'(hcnt_reg) + (CW+1)'(act_val_reg)) <= (CW+1)'(MAX_SLOTS))
        else $error("slot count exceeds capacity");

endmodule
`default_nettype wire

// File: test/tb_frame_slot_pool_manager.sv
// testbench for the frame slot pool manager: scoreboard against a behavioral pool model
`timescale 1ns / 1ps
module tb_frame_slot_pool_manager;

    localparam int NSLOT = 64;
    localparam int CYCLE_LIMIT = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    fspm_pkg::req_t in_req = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    fspm_pkg::rsp_t out_rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    frame_slot_pool_manager #(.MAX_SLOTS(NSLOT)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
        .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // pool model state
    logic [31:0] m_buf_bytes, m_frame_bytes;
    logic [31:0] m_free [NSLOT];
    logic [31:0] m_held [NSLOT];
    int m_free_cnt, m_held_cnt;
    logic [31:0] m_active;
    logic m_active_ok;

    fspm_pkg::req_t pending_reqs [$];
    fspm_pkg::rsp_t expected_rsps [$];
    int errors = 0;
    int cycles = 0;
    bit quiet_idle = 1'b0;
    bit req_taken = 1'b0;
    int in_gap = 0, out_gap = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void enqueue_req(input fspm_pkg::req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic void free_push(input logic [31:0] off);
        if (m_free_cnt < NSLOT)
        begin
            m_free[m_free_cnt] = off;
            m_free_cnt++;
        end
    endfunction

    function automatic fspm_pkg::rsp_t pool_predict(input fspm_pkg::req_t r);
        fspm_pkg::rsp_t o;
        logic [63:0] n;
        int i, j;
        bit hit;
        o = '0;
        o.status = fspm_pkg::ST_OK;
        case (r.func)
            fspm_pkg::FN_SETUP:
            begin
                m_free_cnt = 0;
                m_held_cnt = 0;
                m_active_ok = 1'b0;
                m_active = '0;
                if (m_frame_bytes == 0)
                    o.status = fspm_pkg::ST_INVALID;
                else
                begin
                    n = 64'(m_buf_bytes) / 64'(m_frame_bytes);
                    if (n > NSLOT)
                        o.status = fspm_pkg::ST_NO_ROOM;
                    else
                        for (i = 0; i < int'(n); i++)
                            free_push(32'(64'(i) * 64'(m_frame_bytes)));
                end
            end
            fspm_pkg::FN_RECLAIM:
            begin
                if (m_active_ok)
                begin
                    free_push(m_active);
                    m_active_ok = 1'b0;
                end
                while (m_held_cnt > 0)
                begin
                    m_held_cnt--;
                    free_push(m_held[m_held_cnt]);
                end
            end
            fspm_pkg::FN_GET:
                if (m_active_ok)
                    o.status = fspm_pkg::ST_BAD_STATE;
                else if (m_free_cnt == 0)
                    o.status = fspm_pkg::ST_NOT_FOUND;
                else
                begin
                    m_free_cnt--;
                    m_active = m_free[m_free_cnt];
                    m_active_ok = 1'b1;
                    o.granted_offset = m_active;
                end
            fspm_pkg::FN_COMPLETE:
                if (!m_active_ok)
                    o.status = fspm_pkg::ST_BAD_STATE;
                else
                begin
                    if (m_held_cnt < NSLOT)
                    begin
                        m_held[m_held_cnt] = m_active;
                        m_held_cnt++;
                    end
                    m_active_ok = 1'b0;
                end
            fspm_pkg::FN_RELEASE:
            begin
                hit = 1'b0;
                o.status = fspm_pkg::ST_NOT_FOUND;
                for (i = 0; i < m_held_cnt && !hit; i++)
                    if (m_held[i] == r.release_offset)
                    begin
                        hit = 1'b1;
                        for (j = i; j + 1 < m_held_cnt; j++)
                            m_held[j] = m_held[j + 1];
                        m_held_cnt--;
                        free_push(r.release_offset);
                        o.status = fspm_pkg::ST_OK;
                    end
            end
            default: o.status = fspm_pkg::ST_INVALID;
        endcase
        o.free_slots = 7'(m_free_cnt);
        o.held_slots = 7'(m_held_cnt);
        return o;
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // req_taken marks a request accepted at the last rising edge
            if (req_taken || !in_valid)
            begin
                if (req_taken)
                begin
                    req_taken = 1'b0;
                    void'(pending_reqs.pop_front());
                end
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    in_req <= pending_reqs[0];
                    in_valid <= 1'b1;
                    if (!quiet_idle && $urandom_range(0, 9) == 0)
                        in_gap = $urandom_range(1, 18);
                end
                else
                    in_valid <= 1'b0;
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!quiet_idle && $urandom_range(0, 9) == 0)
                    out_gap = $urandom_range(1, 18);
            end
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        fspm_pkg::rsp_t want;
        if (rst_n)
        begin
            cycles++;
            if (in_valid && !in_stall)
            begin
                req_taken = 1'b1;
                expected_rsps.insert(expected_rsps.size(), pool_predict(in_req));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected response", 32'(out_rsp), '0);
                else
                begin
                    want = expected_rsps.pop_front();
                    if (out_rsp.status !== want.status)
                        report_mismatch("status", 32'(out_rsp.status), 32'(want.status));
                    if (out_rsp.granted_offset !== want.granted_offset)
                        report_mismatch("granted_offset", out_rsp.granted_offset,
                                        want.granted_offset);
                    if (out_rsp.free_slots !== want.free_slots)
                        report_mismatch("free_slots", 32'(out_rsp.free_slots),
                                        32'(want.free_slots));
                    if (out_rsp.held_slots !== want.held_slots)
                        report_mismatch("held_slots", 32'(out_rsp.held_slots),
                                        32'(want.held_slots));
                end
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic fspm_pkg::req_t mk_req(input logic [2:0] f, input logic [31:0] off);
        fspm_pkg::req_t r;
        r.func = f;
        r.release_offset = off;
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (2 * NSLOT + 10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == fspm_pkg::REG_BUFFER_BYTES)
            m_buf_bytes = val;
        else
            m_frame_bytes = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // a mostly well formed frame lifecycle with random content
    task automatic queue_random(input int count, input logic [31:0] fb);
        int k, sel;
        logic [31:0] off;
        for (k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            off = fb * $urandom_range(0, 70);
            if ($urandom_range(0, 15) == 0)
                off = $urandom;
            if (sel < 30)
                enqueue_req(mk_req(fspm_pkg::FN_GET, $urandom));
            else if (sel < 58)
                enqueue_req(mk_req(fspm_pkg::FN_COMPLETE, $urandom));
            else if (sel < 85)
                enqueue_req(mk_req(fspm_pkg::FN_RELEASE, off));
            else if (sel < 91)
                enqueue_req(mk_req(fspm_pkg::FN_RECLAIM, $urandom));
            else if (sel < 96)
                enqueue_req(mk_req(fspm_pkg::FN_SETUP, $urandom));
            else
                enqueue_req(mk_req(3'($urandom_range(5, 7)), $urandom));
        end
    endtask

    initial
    begin
        logic [31:0] fb;
        int ph;
        m_buf_bytes = '0;
        m_frame_bytes = '0;
        m_free_cnt = 0;
        m_held_cnt = 0;
        m_active = '0;
        m_active_ok = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: zero frame size, then operations on an empty pool
        enqueue_req(mk_req(fspm_pkg::FN_SETUP, '0));
        enqueue_req(mk_req(fspm_pkg::FN_GET, '0));
        enqueue_req(mk_req(fspm_pkg::FN_COMPLETE, '0));
        enqueue_req(mk_req(fspm_pkg::FN_RELEASE, 32'hFFFF_FFFF));
        enqueue_req(mk_req(fspm_pkg::FN_RECLAIM, '0));
        enqueue_req(mk_req(3'd5, '0));
        enqueue_req(mk_req(3'd7, 32'hFFFF_FFFF));
        wait_drained();

        // too many slots
        write_reg(fspm_pkg::REG_BUFFER_BYTES, 32'hFFFF_FFFF);
        write_reg(fspm_pkg::REG_FRAME_BYTES, 32'd1);
        enqueue_req(mk_req(fspm_pkg::FN_SETUP, '0));
        enqueue_req(mk_req(fspm_pkg::FN_GET, '0));
        wait_drained();

        // pool one slot short of full, huge frames, releases of offsets not held, then reclaim
        write_reg(fspm_pkg::REG_BUFFER_BYTES, 32'hFFFF_FFFF);
        write_reg(fspm_pkg::REG_FRAME_BYTES, 32'h0400_0000);
        enqueue_req(mk_req(fspm_pkg::FN_SETUP, '0));
        enqueue_req(mk_req(fspm_pkg::FN_GET, '0));
        enqueue_req(mk_req(fspm_pkg::FN_GET, '0));
        enqueue_req(mk_req(fspm_pkg::FN_COMPLETE, '0));
        enqueue_req(mk_req(fspm_pkg::FN_GET, '0));
        enqueue_req(mk_req(fspm_pkg::FN_COMPLETE, '0));
        enqueue_req(mk_req(fspm_pkg::FN_GET, '0));
        enqueue_req(mk_req(fspm_pkg::FN_RELEASE, 32'hFC00_0000));
        enqueue_req(mk_req(fspm_pkg::FN_RELEASE, 32'h1234_5678));
        enqueue_req(mk_req(fspm_pkg::FN_RECLAIM, '0));
        enqueue_req(mk_req(fspm_pkg::FN_GET, '0));
        enqueue_req(mk_req(fspm_pkg::FN_COMPLETE, '0));
        wait_drained();

        // random phases over several geometries
        for (ph = 0; ph < 14; ph++)
        begin
            case (ph % 5)
                0: fb = 32'd1;
                1: fb = $urandom_range(1, 4096);
                2: fb = 32'hFFFF_FFFF;
                3: fb = 32'h8000_0000 >> $urandom_range(0, 6);
                default: fb = $urandom_range(16, 256);
            endcase
            write_reg(fspm_pkg::REG_FRAME_BYTES, fb);
            if (ph % 5 == 2)
                write_reg(fspm_pkg::REG_BUFFER_BYTES, 32'hFFFF_FFFF);
            else
                write_reg(fspm_pkg::REG_BUFFER_BYTES,
                          fb * $urandom_range(0, 64) + $urandom_range(0, 3));
            if (ph == 13)
                quiet_idle = 1'b1;
            enqueue_req(mk_req(fspm_pkg::FN_SETUP, '0));
            queue_random(100, fb);
            wait_drained();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
